/* rtl/ssti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssti_pkg
// Types and constants shared by the sorted sample table interpolator.
// ----------------------------------------------------------------------------
package ssti_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_INTERP = 2'd1,
		CMD_MARK   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_MERGED  = 2'd1,
		STS_DROPPED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ALU_MUL  = 2'd0,
		ALU_DIV  = 2'd1,
		ALU_SQRT = 2'd2
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_CHK,
		S_SCAN_END,
		S_SH_RD,
		S_SH_WR,
		S_ISSUE,
		S_WAIT,
		S_NEXT,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		MS_EA2,
		MS_EB2,
		MS_YMUL,
		MS_YDIV,
		MS_EAB,
		MS_ESQ,
		MS_EDIV,
		MS_SQRT,
		MS_IMUL,
		MS_IDIV,
		MS_WDIV
	} mstep_t;

	localparam int MUL_STEPS  = 64;
	localparam int DIV_STEPS  = 128;
	localparam int SQRT_STEPS = 32;

	typedef struct packed {
		logic           start;
		alu_op_t        op;
		logic [127:0]   opa;
		logic [63:0]    opb;
	} alu_req_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        e;
	} point_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         table_id;
		logic [4:0]         lower_index;
		logic [16:0]        weight_lower;
		logic [16:0]        weight_upper;
		logic               hit;
		logic [1:0]         status;
		logic               last;
	} res_t;

endpackage

/* rtl/ssti_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssti_cmd_if / ssti_res_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface ssti_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [1:0]         table_sel;
	logic signed [31:0] key_x;
	logic signed [31:0] value_y;
	logic [30:0]        error_y;
	modport source(output valid, command, table_sel, key_x, value_y, error_y, input ready);
	modport sink(input valid, command, table_sel, key_x, value_y, error_y, output ready);
endinterface

interface ssti_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic [1:0]         table_id;
	logic [4:0]         lower_index;
	logic [16:0]        weight_lower;
	logic [16:0]        weight_upper;
	logic               hit;
	logic [1:0]         status;
	logic               last;
	modport source(output valid, result_value, table_id, lower_index, weight_lower,
		weight_upper, hit, status, last, input ready);
	modport sink(input valid, result_value, table_id, lower_index, weight_lower,
		weight_upper, hit, status, last, output ready);
endinterface

/* rtl/ssti_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssti_alu
// Shared bit-serial unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
module ssti_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  ssti_pkg::alu_req_t req,
	output logic              done,
	output logic [127:0]      res
);
	import ssti_pkg::*;

	logic         busy_q, done_q;
	alu_op_t      op_q;
	logic [6:0]   cnt_q;
	logic [127:0] acc_q, sh_q;
	logic [65:0]  rem_q;
	logic [63:0]  opd_q;

	logic [127:0] mul_nx;
	logic [64:0]  div_r, div_rem;
	logic         div_ge;
	logic [65:0]  sq_r, sq_t, sq_rem;
	logic         sq_ge;
	logic         last_step;

	always_comb begin
		mul_nx  = {acc_q[126:0], 1'b0} + (sh_q[63] ? {64'd0, opd_q} : 128'd0);
		div_r   = {rem_q[63:0], sh_q[127]};
		div_ge  = div_r >= {1'b0, opd_q};
		div_rem = div_ge ? div_r - {1'b0, opd_q} : div_r;
		sq_r    = {rem_q[63:0], sh_q[63:62]};
		sq_t    = {acc_q[63:0], 2'b01};
		sq_ge   = sq_r >= sq_t;
		sq_rem  = sq_ge ? sq_r - sq_t : sq_r;
		case (op_q)
			ALU_MUL:  last_step = cnt_q == 7'(MUL_STEPS - 1);
			ALU_DIV:  last_step = cnt_q == 7'(DIV_STEPS - 1);
			ALU_SQRT: last_step = cnt_q == 7'(SQRT_STEPS - 1);
			default:  last_step = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= '0;
				acc_q  <= '0;
				rem_q  <= '0;
				case (req.op)
					ALU_MUL: begin
						opd_q <= req.opa[63:0];
						sh_q  <= {64'd0, req.opb};
					end
					ALU_DIV: begin
						opd_q <= req.opb;
						sh_q  <= req.opa;
					end
					default: begin
						opd_q <= req.opb;
						sh_q  <= {64'd0, req.opa[63:0]};
					end
				endcase
			end else if (busy_q) begin
				case (op_q)
					ALU_MUL: begin
						acc_q <= mul_nx;
						sh_q  <= sh_q << 1;
					end
					ALU_DIV: begin
						acc_q <= {acc_q[126:0], div_ge};
						rem_q <= {1'b0, div_rem};
						sh_q  <= sh_q << 1;
					end
					default: begin
						acc_q <= {acc_q[126:0], sq_ge};
						rem_q <= sq_rem;
						sh_q  <= sh_q << 2;
					end
				endcase
				cnt_q <= cnt_q + 7'd1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;
endmodule

/* rtl/ssti_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssti_store
// Point memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssti_store #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  ssti_pkg::point_t wdata,
	input  logic [AW-1:0]   raddr,
	output ssti_pkg::point_t rdata
);
	import ssti_pkg::*;

	point_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/sorted_sample_table_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sample_table_interpolator
// Sorted (x, y, err) tables with merge on equal x, interpolation and marks.
// ----------------------------------------------------------------------------
// Insert scans the table and shifts the later points up; a merge on equal x
//   runs multiplies, divides and a square root in the shared unit.
// Interpolate: per table a scan, plus a multiply and a divide on a hit.
// Mark: per table a scan, plus a divide on a hit, one result each.
// One command at a time; the scan over the single point memory port and the
//   bit-serial unit set the rate. Reset clears all counts at once; no sweep.
module sorted_sample_table_interpolator #(
	parameter int NUM_TABLES       = 4,
	parameter int POINTS_PER_TABLE = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	ssti_cmd_if.sink     cmd_ch,
	ssti_res_if.source   res_ch
);
	import ssti_pkg::*;

	localparam int DEPTH   = NUM_TABLES * POINTS_PER_TABLE;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(POINTS_PER_TABLE + 1);
	localparam int TW      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int REPORTS = (NUM_TABLES < 4) ? NUM_TABLES : 4;
	localparam int SW      = 36 + TW;

	state_t   state_q, state_d;
	mstep_t   step_q;
	cmd_t     cmd_q;
	logic signed [31:0] x_q, y_q;
	logic [30:0]        ey_q;
	logic [TW-1:0]      tbl_q;
	logic [CW-1:0]      j_q, k_q;
	logic [CW-1:0]      cnt_q [NUM_TABLES];
	point_t             cur_q, prev_q, rd;
	logic               found_q, dyneg_q;
	logic [127:0]       r_q;
	logic [61:0]        ea2_q;
	logic [62:0]        s_q;
	logic [32:0]        num_q, dx_q, mag_q;
	logic signed [31:0] ynew_q;
	logic signed [SW-1:0] sum_q;
	logic               any_q;
	logic               out_valid_q;
	res_t               res_q, res_d;

	logic [CW-1:0]  n_cur;
	logic [AW-1:0]  base, raddr, waddr;
	logic           we;
	point_t         wdata;
	alu_req_t       alu_req;
	logic           alu_done;
	logic [127:0]   alu_res;
	logic           hit_c, accept, load_out;
	logic signed [33:0] ival;
	logic signed [32:0] sx_dy;
	logic [16:0]    wu;
	logic [31:0]    root;

	ssti_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.done   (alu_done),
		.res    (alu_res)
	);

	ssti_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	assign accept = cmd_ch.valid && cmd_ch.ready;
	assign cmd_ch.ready = (state_q == S_IDLE);
	assign n_cur = cnt_q[tbl_q];
	assign base  = AW'(AW'(tbl_q) * AW'(POINTS_PER_TABLE));
	assign hit_c = found_q && (j_q != '0);
	assign ival  = dyneg_q ? 34'(prev_q.y) - $signed({1'b0, alu_res[32:0]})
		: 34'(prev_q.y) + $signed({1'b0, alu_res[32:0]});
	assign wu    = alu_res[16:0];
	assign root  = alu_res[31:0];
	// insert weighs new against stored y, queries take the bracket's slope
	assign sx_dy = (cmd_q == CMD_INSERT) ? 33'(y_q) - 33'(cur_q.y)
		: 33'(cur_q.y) - 33'(prev_q.y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		raddr    = base + AW'(j_q);
		waddr    = base + AW'(j_q);
		we       = 1'b0;
		wdata    = '{x: x_q, y: y_q, e: {1'b0, ey_q}};
		alu_req  = '0;
		load_out = 1'b0;
		res_d    = '0;
		res_d.last   = 1'b1;
		res_d.status = STS_OK;
		case (state_q)
			S_IDLE: begin
				if (cmd_ch.valid) begin
					case (cmd_t'(cmd_ch.command))
						CMD_INSERT: begin
							if (32'(cmd_ch.table_sel) >= NUM_TABLES) begin
								res_d.status = STS_DROPPED;
								load_out = 1'b1;
								state_d  = S_OUT;
							end else begin
								state_d = S_SCAN;
							end
						end
						CMD_CLEAR: begin
							load_out = 1'b1;
							state_d  = S_OUT;
						end
						default: state_d = S_SCAN;
					endcase
				end
			end
			S_SCAN: begin
				state_d = (j_q == n_cur) ? S_SCAN_END : S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				state_d = ($signed(x_q) <= $signed(rd.x)) ? S_SCAN_END : S_SCAN;
			end
			S_SCAN_END: begin
				case (cmd_q)
					CMD_INSERT: begin
						if (found_q && cur_q.x == x_q) begin
							state_d = S_ISSUE;
						end else if (n_cur == CW'(POINTS_PER_TABLE)) begin
							res_d.status = STS_DROPPED;
							load_out = 1'b1;
							state_d  = S_OUT;
						end else begin
							state_d = S_SH_RD;
						end
					end
					CMD_INTERP: state_d = hit_c ? S_ISSUE : S_NEXT;
					default: begin
						if (hit_c) begin
							state_d = S_ISSUE;
						end else begin
							res_d.table_id = 2'(tbl_q);
							res_d.last     = tbl_q == TW'(REPORTS - 1);
							load_out = 1'b1;
							state_d  = S_OUT;
						end
					end
				endcase
			end
			S_SH_RD: begin
				raddr = base + AW'(k_q - CW'(1));
				if (k_q == j_q) begin
					we       = 1'b1;
					load_out = 1'b1;
					state_d  = S_OUT;
				end else begin
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				// move the entry just read one place up
				we      = 1'b1;
				waddr   = base + AW'(k_q);
				wdata   = rd;
				state_d = S_SH_RD;
			end
			S_ISSUE: begin
				alu_req.start = 1'b1;
				case (step_q)
					MS_EA2: begin
						alu_req.op  = ALU_MUL;
						alu_req.opa = {96'd0, cur_q.e};
						alu_req.opb = {32'd0, cur_q.e};
					end
					MS_EB2: begin
						alu_req.op  = ALU_MUL;
						alu_req.opa = {97'd0, ey_q};
						alu_req.opb = {33'd0, ey_q};
					end
					MS_YMUL: begin
						alu_req.op  = ALU_MUL;
						alu_req.opa = {95'd0, mag_q};
						alu_req.opb = {2'd0, ea2_q};
					end
					MS_YDIV: begin
						alu_req.op  = ALU_DIV;
						alu_req.opa = r_q + {66'd0, s_q[62:1]};
						alu_req.opb = {1'b0, s_q};
					end
					MS_EAB: begin
						alu_req.op  = ALU_MUL;
						alu_req.opa = {96'd0, cur_q.e};
						alu_req.opb = {33'd0, ey_q};
					end
					MS_ESQ: begin
						alu_req.op  = ALU_MUL;
						alu_req.opa = {64'd0, r_q[63:0]};
						alu_req.opb = r_q[63:0];
					end
					MS_EDIV: begin
						alu_req.op  = ALU_DIV;
						alu_req.opa = r_q;
						alu_req.opb = {1'b0, s_q};
					end
					MS_SQRT: begin
						alu_req.op  = ALU_SQRT;
						alu_req.opa = {64'd0, r_q[63:0]};
					end
					MS_IMUL: begin
						alu_req.op  = ALU_MUL;
						alu_req.opa = {95'd0, num_q};
						alu_req.opb = {31'd0, mag_q};
					end
					MS_IDIV: begin
						alu_req.op  = ALU_DIV;
						alu_req.opa = r_q + {96'd0, dx_q[32:1]};
						alu_req.opb = {31'd0, dx_q};
					end
					default: begin
						alu_req.op  = ALU_DIV;
						alu_req.opa = {79'd0, num_q, 16'd0} + {96'd0, dx_q[32:1]};
						alu_req.opb = {31'd0, dx_q};
					end
				endcase
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (alu_done) begin
					case (step_q)
						MS_SQRT: begin
							we       = 1'b1;
							wdata    = '{x: cur_q.x, y: ynew_q,
								e: (root == 32'd0) ? 32'd1 : root};
							res_d.status = STS_MERGED;
							load_out = 1'b1;
							state_d  = S_OUT;
						end
						MS_IDIV: state_d = S_NEXT;
						MS_WDIV: begin
							res_d.table_id     = 2'(tbl_q);
							res_d.lower_index  = 5'(j_q - CW'(1));
							res_d.weight_upper = wu;
							res_d.weight_lower = 17'd65536 - wu;
							res_d.hit          = 1'b1;
							res_d.last         = tbl_q == TW'(REPORTS - 1);
							load_out = 1'b1;
							state_d  = S_OUT;
						end
						default: state_d = S_ISSUE;
					endcase
				end
			end
			S_NEXT: begin
				if (tbl_q == TW'(NUM_TABLES - 1)) begin
					if (sum_q > SW'(64'sd2147483647)) begin
						res_d.result_value = 32'sh7FFFFFFF;
					end else if (sum_q < -SW'(64'sd2147483648)) begin
						res_d.result_value = 32'sh80000000;
					end else begin
						res_d.result_value = 32'(sum_q);
					end
					res_d.hit = any_q;
					load_out  = 1'b1;
					state_d   = S_OUT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_OUT: begin
				if (res_ch.ready) begin
					state_d = (cmd_q == CMD_MARK && tbl_q != TW'(REPORTS - 1)) ? S_SCAN : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int t = 0; t < NUM_TABLES; t++) begin
				cnt_q[t] <= '0;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (state_q == S_OUT && res_ch.ready) begin
				out_valid_q <= 1'b0;
				if (state_d == S_SCAN) begin
					tbl_q <= tbl_q + TW'(1);
					j_q   <= '0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd_t'(cmd_ch.command);
						x_q   <= cmd_ch.key_x;
						y_q   <= cmd_ch.value_y;
						ey_q  <= (cmd_ch.error_y == '0) ? 31'd1 : cmd_ch.error_y;
						tbl_q <= (cmd_t'(cmd_ch.command) == CMD_INSERT) ? TW'(cmd_ch.table_sel) : '0;
						j_q   <= '0;
						sum_q <= '0;
						any_q <= 1'b0;
						if (cmd_t'(cmd_ch.command) == CMD_CLEAR) begin
							for (int t = 0; t < NUM_TABLES; t++) begin
								cnt_q[t] <= '0;
							end
						end
					end
				end
				S_SCAN: begin
					if (j_q == n_cur) begin
						found_q <= 1'b0;
					end
				end
				S_SCAN_CHK: begin
					cur_q <= rd;
					if ($signed(x_q) <= $signed(rd.x)) begin
						found_q <= 1'b1;
					end else begin
						prev_q <= rd;
						j_q    <= j_q + CW'(1);
					end
				end
				S_SCAN_END: begin
					k_q   <= n_cur;
					num_q <= 33'(x_q) - 33'(prev_q.x);
					dx_q  <= 33'(cur_q.x) - 33'(prev_q.x);
					if (cmd_q == CMD_INSERT) begin
						step_q  <= MS_EA2;
					end else begin
						step_q  <= (cmd_q == CMD_INTERP) ? MS_IMUL : MS_WDIV;
					end
					dyneg_q <= sx_dy[32];
					mag_q   <= sx_dy[32] ? 33'(-sx_dy) : 33'(sx_dy);
				end
				S_SH_RD: begin
					if (k_q == j_q) begin
						cnt_q[tbl_q] <= n_cur + CW'(1);
					end
				end
				S_SH_WR: begin
					k_q <= k_q - CW'(1);
				end
				S_WAIT: begin
					if (alu_done) begin
						r_q <= alu_res;
						case (step_q)
							MS_EA2: begin
								ea2_q  <= alu_res[61:0];
								step_q <= MS_EB2;
							end
							MS_EB2: begin
								s_q    <= {1'b0, ea2_q} + {1'b0, alu_res[61:0]};
								step_q <= MS_YMUL;
							end
							MS_YMUL: step_q <= MS_YDIV;
							MS_YDIV: begin
								ynew_q <= 32'(dyneg_q ? 34'(cur_q.y) - $signed({1'b0, alu_res[32:0]})
									: 34'(cur_q.y) + $signed({1'b0, alu_res[32:0]}));
								step_q <= MS_EAB;
							end
							MS_EAB:  step_q <= MS_ESQ;
							MS_ESQ:  step_q <= MS_EDIV;
							MS_EDIV: step_q <= MS_SQRT;
							MS_IMUL: step_q <= MS_IDIV;
							MS_IDIV: begin
								sum_q <= sum_q + SW'(ival);
								any_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_NEXT: begin
					if (tbl_q != TW'(NUM_TABLES - 1)) begin
						tbl_q <= tbl_q + TW'(1);
						j_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign res_ch.valid        = out_valid_q;
	assign res_ch.result_value = res_q.result_value;
	assign res_ch.table_id     = res_q.table_id;
	assign res_ch.lower_index  = res_q.lower_index;
	assign res_ch.weight_lower = res_q.weight_lower;
	assign res_ch.weight_upper = res_q.weight_upper;
	assign res_ch.hit          = res_q.hit;
	assign res_ch.status       = res_q.status;
	assign res_ch.last         = res_q.last;
endmodule

/* rtl/ssti_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssti_check
// Port-level checks for the interpolator, attached by bind.
// ----------------------------------------------------------------------------
module ssti_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_status,
	input logic        out_last,
	input logic [31:0] out_value
);
	import ssti_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("command taken while a result is pending");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a command");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status != 2'd3)
		else $error("bad status code");

	a_mark_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_status == STS_OK && out_value == 32'd0)
		else $error("non-final result not a mark");
endmodule

bind sorted_sample_table_interpolator ssti_check u_ssti_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd_ch.valid),
	.in_ready   (cmd_ch.ready),
	.out_valid  (res_ch.valid),
	.out_ready  (res_ch.ready),
	.out_status (res_ch.status),
	.out_last   (res_ch.last),
	.out_value  (res_ch.result_value)
);

/* bench/sorted_sample_table_interpolator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sample_table_interpolator_tb
// Drives insert, interpolate, mark and clear transactions through the command
// channel with random gaps and checks every result against a built-in table
// predictor, field by field and in order, under random result back-pressure.
// ----------------------------------------------------------------------------
module sorted_sample_table_interpolator_tb;
	import ssti_pkg::*;

	localparam int NT = 4;
	localparam int NP = 32;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		cmd_t               cmd;
		logic [1:0]         sel;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [30:0]        e;
		bit                 sync;
	} cmd_item_t;

	logic clk = 1'b0;
	logic arst_n;

	ssti_cmd_if cmd_ch();
	ssti_res_if res_ch();

	sorted_sample_table_interpolator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	cmd_item_t pending_cmds[$];
	res_t      expected_results[$];

	// predictor copy of the tables
	logic signed [31:0] tab_x[NT][NP];
	logic signed [31:0] tab_y[NT][NP];
	logic [31:0]        tab_e[NT][NP];
	int                 tab_n[NT];

	int  errors = 0;
	int  n_accepted = 0;
	int  n_results = 0;
	int  n_merged = 0;
	int  n_dropped = 0;
	int  n_hits = 0;
	int  cmd_gap = 0;
	int  res_gap = 0;
	int  res_hold = 0;
	bit  hold_done = 0;
	longint cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int rand_gap(int seq);
		int r;
		r = $urandom_range(0, 99);
		if (seq % 100 < 25)
			return 0;
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [63:0] isqrt64(logic [63:0] n);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic int find_interval(int t, logic signed [31:0] x);
		for (int i = 0; i + 1 < tab_n[t]; i++)
			if (x > tab_x[t][i] && x <= tab_x[t][i + 1])
				return i;
		return -1;
	endfunction

	function automatic res_t blank_result();
		res_t r;
		r = '0;
		r.status = STS_OK;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic merge_point(int t, int k, logic signed [31:0] b, logic [31:0] eb);
		logic [127:0] ea, ea2, eb2, s, mag, q, p;
		longint       a, d;
		a = tab_y[t][k];
		ea = tab_e[t][k];
		ea2 = ea * ea;
		eb2 = {96'd0, eb} * {96'd0, eb};
		s = ea2 + eb2;
		d = longint'(b) - a;
		mag = (d < 0) ? -d : d;
		q = (mag * ea2 + (s >> 1)) / s;
		tab_y[t][k] = (d < 0) ? 32'(a - longint'(q)) : 32'(a + longint'(q));
		p = ea * {96'd0, eb};
		q = isqrt64(64'((p * p) / s));
		tab_e[t][k] = (q == 0) ? 32'd1 : q[31:0];
	endtask

	task automatic predict_table_op(cmd_item_t it);
		res_t         r;
		logic [31:0]  ey;
		int           pos, i;
		longint       num, dx, dy, sum;
		logic [127:0] mag, q;
		bit           any;
		ey = (it.e == 0) ? 32'd1 : {1'b0, it.e};
		r = blank_result();
		case (it.cmd)
			CMD_INSERT: begin
				pos = 0;
				while (pos < tab_n[it.sel] && tab_x[it.sel][pos] < it.x)
					pos++;
				if (pos < tab_n[it.sel] && tab_x[it.sel][pos] == it.x) begin
					merge_point(it.sel, pos, it.y, ey);
					r.status = STS_MERGED;
					n_merged++;
				end else if (tab_n[it.sel] >= NP) begin
					r.status = STS_DROPPED;
					n_dropped++;
				end else begin
					for (int j = tab_n[it.sel]; j > pos; j--) begin
						tab_x[it.sel][j] = tab_x[it.sel][j - 1];
						tab_y[it.sel][j] = tab_y[it.sel][j - 1];
						tab_e[it.sel][j] = tab_e[it.sel][j - 1];
					end
					tab_x[it.sel][pos] = it.x;
					tab_y[it.sel][pos] = it.y;
					tab_e[it.sel][pos] = ey;
					tab_n[it.sel]++;
				end
				expected_results.push_back(r);
			end
			CMD_INTERP: begin
				sum = 0;
				any = 0;
				for (int t = 0; t < NT; t++) begin
					i = find_interval(t, it.x);
					if (i >= 0) begin
						any = 1;
						num = longint'(it.x) - tab_x[t][i];
						dx = longint'(tab_x[t][i + 1]) - tab_x[t][i];
						dy = longint'(tab_y[t][i + 1]) - tab_y[t][i];
						mag = (dy < 0) ? -dy : dy;
						q = (128'(num) * mag + 128'(dx >> 1)) / 128'(dx);
						sum += (dy < 0) ? longint'(tab_y[t][i]) - longint'(q)
							: longint'(tab_y[t][i]) + longint'(q);
					end
				end
				if (sum > 64'sd2147483647)
					sum = 64'sd2147483647;
				if (sum < -64'sd2147483648)
					sum = -64'sd2147483648;
				r.result_value = sum[31:0];
				r.hit = any;
				if (any)
					n_hits++;
				expected_results.push_back(r);
			end
			CMD_MARK: begin
				for (int t = 0; t < NT; t++) begin
					r = blank_result();
					r.table_id = t;
					r.last = (t == NT - 1);
					i = find_interval(t, it.x);
					if (i >= 0) begin
						num = longint'(it.x) - tab_x[t][i];
						dx = longint'(tab_x[t][i + 1]) - tab_x[t][i];
						q = ((128'(num) << 16) + 128'(dx >> 1)) / 128'(dx);
						r.lower_index = i;
						r.weight_upper = q[16:0];
						r.weight_lower = 17'd65536 - q[16:0];
						r.hit = 1'b1;
						n_hits++;
					end
					expected_results.push_back(r);
				end
			end
			default: begin
				for (int t = 0; t < NT; t++)
					tab_n[t] = 0;
				expected_results.push_back(r);
			end
		endcase
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t ns: mismatch in %s: expected %0d, actual %0d",
				$time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t it;
		cmd_item_t acc;
		if (!arst_n) begin
			cmd_ch.valid     <= 1'b0;
			cmd_ch.command   <= CMD_INSERT;
			cmd_ch.table_sel <= '0;
			cmd_ch.key_x     <= '0;
			cmd_ch.value_y   <= '0;
			cmd_ch.error_y   <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				acc.cmd = cmd_t'(cmd_ch.command);
				acc.sel = cmd_ch.table_sel;
				acc.x = cmd_ch.key_x;
				acc.y = cmd_ch.value_y;
				acc.e = cmd_ch.error_y;
				predict_table_op(acc);
				n_accepted++;
				cmd_gap = rand_gap(n_accepted);
			end
			if (!(cmd_ch.valid && !cmd_ch.ready)) begin
				if (cmd_gap > 0) begin
					cmd_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds.size() != 0 &&
						!(pending_cmds[0].sync && expected_results.size() != 0)) begin
					it = pending_cmds.pop_front();
					cmd_ch.valid     <= 1'b1;
					cmd_ch.command   <= it.cmd;
					cmd_ch.table_sel <= it.sel;
					cmd_ch.key_x     <= it.x;
					cmd_ch.value_y   <= it.y;
					cmd_ch.error_y   <= it.e;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, mid run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_hold <= 0;
		end else if (!hold_done && n_results >= 80) begin
			hold_done <= 1;
			res_hold <= 3000;
		end else if (res_hold > 0) begin
			res_hold <= res_hold - 1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		res_t ex;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$display("%0t ns: unexpected result, value %0d status %0d",
						$time, res_ch.result_value, res_ch.status);
					errors++;
				end else begin
					ex = expected_results.pop_front();
					check_field("result_value", ex.result_value, res_ch.result_value);
					check_field("table_id", ex.table_id, res_ch.table_id);
					check_field("lower_index", ex.lower_index, res_ch.lower_index);
					check_field("weight_lower", ex.weight_lower, res_ch.weight_lower);
					check_field("weight_upper", ex.weight_upper, res_ch.weight_upper);
					check_field("hit", ex.hit, res_ch.hit);
					check_field("status", ex.status, res_ch.status);
					check_field("last", ex.last, res_ch.last);
				end
			end
			if (res_gap > 0)
				res_gap--;
			else if (res_ch.valid && res_ch.ready)
				res_gap = rand_gap(n_results + 40);
			res_ch.ready <= (res_hold == 0) && (res_gap == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic add_cmd(cmd_t c, int sel, logic signed [31:0] x,
			logic signed [31:0] y, logic [30:0] e, bit sync = 0);
		cmd_item_t it;
		it.cmd = c;
		it.sel = sel;
		it.x = x;
		it.y = y;
		it.e = e;
		it.sync = sync;
		pending_cmds.push_back(it);
	endtask

	function automatic logic signed [31:0] rand_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return ($signed($urandom_range(0, 32)) - 16) <<< 16;
		if (r < 85)
			return (($signed($urandom_range(0, 32)) - 16) <<< 16) + $urandom_range(0, 65535);
		return $urandom;
	endfunction

	function automatic logic signed [31:0] rand_value();
		if ($urandom_range(0, 9) < 7)
			return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
		return $urandom;
	endfunction

	function automatic logic [30:0] rand_error();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return $urandom_range(1, 4 << 16);
		if (r < 9)
			return 31'd0;
		return $urandom;
	endfunction

	initial begin
		int  r;
		bit  filled;
		arst_n = 1'b0;
		for (int t = 0; t < NT; t++)
			tab_n[t] = 0;

		// directed: extremes, empty and single point tables, merges, saturation
		add_cmd(CMD_INTERP, 0, 0, 0, 1);
		add_cmd(CMD_MARK, 0, 0, 0, 1);
		add_cmd(CMD_INSERT, 0, 32'sh8000_0000, 32'sh8000_0000, 31'd1);
		add_cmd(CMD_MARK, 0, 32'sh7fff_ffff, 0, 1);
		add_cmd(CMD_INSERT, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff);
		add_cmd(CMD_INTERP, 0, 32'sh8000_0000, 0, 1);
		add_cmd(CMD_INTERP, 0, 32'sh7fff_ffff, 0, 1);
		add_cmd(CMD_MARK, 0, 0, 0, 1);
		add_cmd(CMD_INSERT, 0, 0, 32'sh0001_0000, 31'd0);
		add_cmd(CMD_INSERT, 0, 0, 32'shffff_0000, 31'd0);
		add_cmd(CMD_INSERT, 0, 0, 32'sh7fff_ffff, 31'h7fff_ffff);
		for (int t = 1; t < NT; t++) begin
			add_cmd(CMD_INSERT, t, -32'sd655360, 32'sh7fff_ffff, 31'h10000);
			add_cmd(CMD_INSERT, t, 32'sd655360, 32'sh7fff_ffff, 31'h10000);
		end
		add_cmd(CMD_INTERP, 0, 32'sd327680, 0, 1);
		add_cmd(CMD_MARK, 0, 32'sd655360, 0, 1);
		add_cmd(CMD_CLEAR, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff);
		add_cmd(CMD_INSERT, 3, 32'sd1, 32'sh8000_0000, 31'd1);
		add_cmd(CMD_INSERT, 3, 32'sd2, 32'sh8000_0000, 31'd1);
		add_cmd(CMD_INSERT, 2, 32'sd1, 32'sh8000_0000, 31'd1);
		add_cmd(CMD_INSERT, 2, 32'sd2, 32'sh8000_0000, 31'd1);
		add_cmd(CMD_INTERP, 0, 32'sd2, 0, 1);

		// random: mostly table building and queries, with one fill to overflow
		filled = 0;
		while (pending_cmds.size() < 270) begin
			r = $urandom_range(0, 99);
			if (!filled && pending_cmds.size() > 60) begin
				filled = 1;
				r = $urandom_range(0, 3);
				add_cmd(CMD_CLEAR, 0, 0, 0, 1, 1);
				for (int k = 0; k < NP + 2; k++)
					add_cmd(CMD_INSERT, r, (k - 16) <<< 16, rand_value(), rand_error());
				add_cmd(CMD_INSERT, r, 5 <<< 16, rand_value(), rand_error());
				add_cmd(CMD_MARK, 0, rand_key(), 0, 1);
			end else if (r < 45) begin
				add_cmd(CMD_INSERT, $urandom_range(0, 3), rand_key(), rand_value(),
					rand_error());
			end else if (r < 65) begin
				add_cmd(CMD_INTERP, $urandom_range(0, 3), rand_key(), $urandom, $urandom);
			end else if (r < 85) begin
				add_cmd(CMD_MARK, $urandom_range(0, 3), rand_key(), $urandom, $urandom);
			end else if (r < 88) begin
				add_cmd(CMD_CLEAR, $urandom_range(0, 3), $urandom, $urandom, $urandom);
			end else begin
				add_cmd(CMD_INSERT, $urandom_range(0, 3), $urandom, $urandom, $urandom);
			end
		end
		pending_cmds[200].sync = 1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived",
				$time, expected_results.size());
			errors++;
		end
		$display("covered %0d commands, %0d results: %0d merges, %0d drops, %0d hits",
			n_accepted, n_results, n_merged, n_dropped, n_hits);
		$display("%0d mismatches seen", errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sorted_sample_table_interpolator.f */
rtl/ssti_pkg.sv
rtl/ssti_if.sv
rtl/ssti_alu.sv
rtl/ssti_store.sv
rtl/sorted_sample_table_interpolator.sv
rtl/ssti_check.sv
bench/sorted_sample_table_interpolator_tb.sv
